>>> hw/rtl/agp_pkg.sv
package agp_pkg;

	localparam int DEF_MAX_ZOOM = 8;
	localparam int ZOOM_W       = 4;
	localparam int COORD_W      = 6;
	localparam int GLYPH_DIM    = 8;
	localparam int SUM_W        = 8;   // bilinear weight sum, at most zoom squared
	localparam int NUM_W        = 17;  // 510*sum + zoom squared
	localparam int DEN_W        = 9;   // 2 * zoom squared
	localparam int ALPHA_W      = 8;
	localparam int MIX_W        = 14;  // 63*255 fits
	localparam int LATENCY      = 9;   // accept edge to the edge that samples done

	typedef logic [ZOOM_W-1:0]  zoom_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [SUM_W-1:0]   wsum_t;
	typedef logic [ALPHA_W-1:0] alpha_t;

	typedef struct packed {
		logic [63:0] glyph_bits;
		logic [15:0] fore_color;
		logic [15:0] back_color;
		zoom_t       zoom;
		coord_t      pixel_x;
		coord_t      pixel_y;
	} agp_req_t;

	typedef struct packed {
		logic [15:0] pixel_word;
		alpha_t      coverage_alpha;
	} agp_rsp_t;

	typedef struct packed {
		logic [15:0] fore;
		logic [15:0] back;
	} agp_cols_t;

endpackage

>>> hw/rtl/agp_alpha_div.sv
// Rounded coverage: alpha = floor((510*S + zz) / (2*zz)), restoring divide,
// four quotient bits per stage. Quotient never exceeds 255 since S <= zz.
module agp_alpha_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld,
	input  agp_pkg::wsum_t     wsum,
	input  agp_pkg::wsum_t     zz,
	input  agp_pkg::agp_cols_t cols,
	output logic               res_vld,
	output agp_pkg::alpha_t    quot,
	output agp_pkg::agp_cols_t res_cols
);

	localparam int NW = agp_pkg::NUM_W;
	localparam int DW = agp_pkg::DEN_W;
	localparam int QW = agp_pkg::ALPHA_W;
	localparam int HQ = QW / 2;

	logic               vld_s5, vld_s6, vld_s7;
	logic [NW-1:0]      num_s5, rem_s6;
	logic [DW-1:0]      den_s5, den_s6;
	logic [QW-1:0]      q_s6, q_s7;
	agp_pkg::agp_cols_t cols_s5, cols_s6, cols_s7;

	logic [NW-1:0]      num_d, rem_hi, rem_lo;
	logic [QW-1:0]      q_hi, q_lo;

	// 510*S as 512*S - 2*S
	always_comb begin
		num_d = {wsum, 9'b0} - NW'({wsum, 1'b0}) + NW'(zz);
	end

	always_comb begin
		logic [NW-1:0] dsh;
		rem_hi = num_s5;
		q_hi   = '0;
		for (int k = QW - 1; k >= HQ; k--) begin
			dsh = NW'(den_s5) << k;
			if (rem_hi >= dsh) begin
				rem_hi  = rem_hi - dsh;
				q_hi[k] = 1'b1;
			end
		end
	end

	always_comb begin
		logic [NW-1:0] dsh;
		rem_lo = rem_s6;
		q_lo   = q_s6;
		for (int k = HQ - 1; k >= 0; k--) begin
			dsh = NW'(den_s6) << k;
			if (rem_lo >= dsh) begin
				rem_lo  = rem_lo - dsh;
				q_lo[k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s5 <= vld;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		num_s5  <= num_d;
		den_s5  <= {zz, 1'b0};
		cols_s5 <= cols;
		rem_s6  <= rem_hi;
		den_s6  <= den_s5;
		q_s6    <= q_hi;
		cols_s6 <= cols_s5;
		q_s7    <= q_lo;
		cols_s7 <= cols_s6;
	end

	assign res_vld  = vld_s7;
	assign quot     = q_s7;
	assign res_cols = cols_s7;

endmodule

>>> hw/rtl/antialiased_glyph_pixel_core.sv
// Channel   Handshake            Beat type          Notes
// request   start / busy         agp_pkg::agp_req_t taken when start & !busy
// result    done (strobe)        agp_pkg::agp_rsp_t valid for the single done cycle
//
// Nine-stage pipeline; one beat may enter every cycle, busy stays low.
// done is the valid bit of the last stage register; a beat passes the alpha
// divider (three stages) and the blend multiply/divide on its way there.
// arst_n clears all stage valid bits; the datapath registers are not reset.
// The receiver cannot stall, so nothing backs up and no beat is dropped.
module antialiased_glyph_pixel_core #(
	parameter int MAX_ZOOM = agp_pkg::DEF_MAX_ZOOM
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  agp_pkg::agp_req_t req,
	output logic              done,
	output agp_pkg::agp_rsp_t rsp
);

	localparam int CW  = agp_pkg::COORD_W;
	localparam int MW  = agp_pkg::MIX_W;

	// ---------------------------------------------------------------------
	// Coordinate divide by zoom: three quotient bits since coord < 8*zoom.
	// Returns {quotient[2:0], remainder[3:0]}.
	// ---------------------------------------------------------------------
	function automatic logic [6:0] coord_div(input agp_pkg::coord_t p, input agp_pkg::zoom_t z);
		logic [6:0] rem;
		logic [6:0] dz;
		logic [2:0] q;
		rem = {1'b0, p};
		q   = '0;
		for (int k = 2; k >= 0; k--) begin
			dz = 7'(z) << k;
			if (rem >= dz) begin
				rem  = rem - dz;
				q[k] = 1'b1;
			end
		end
		return {q, rem[3:0]};
	endfunction

	// x/255 for x <= 63*255 (the blend sums), exact: (x + 1 + (x >> 8)) >> 8
	function automatic logic [5:0] div255(input logic [MW-1:0] x);
		logic [MW:0] t;
		t = (MW+1)'(x) + (MW+1)'(1) + (MW+1)'(x >> 8);
		return 6'(t >> 8);
	endfunction

	// ---------------------------------------------------------------------
	// Stage 1: zoom clamp and coordinate saturation
	// ---------------------------------------------------------------------
	logic               vld_s1;
	logic [63:0]        glyph_s1;
	agp_pkg::agp_cols_t cols_s1;
	agp_pkg::zoom_t     zc_s1;
	agp_pkg::coord_t    px_s1, py_s1;

	agp_pkg::zoom_t     zc_d;
	logic [CW:0]        lim_d;
	agp_pkg::coord_t    px_d, py_d;

	always_comb begin
		zc_d = (req.zoom == '0) ? agp_pkg::zoom_t'(1) : req.zoom;
		if (32'(zc_d) > MAX_ZOOM) begin
			zc_d = agp_pkg::zoom_t'(MAX_ZOOM);
		end
		lim_d = {zc_d, 3'b000} - (CW+1)'(1);
		px_d  = ({1'b0, req.pixel_x} > lim_d) ? lim_d[CW-1:0] : req.pixel_x;
		py_d  = ({1'b0, req.pixel_y} > lim_d) ? lim_d[CW-1:0] : req.pixel_y;
	end

	// ---------------------------------------------------------------------
	// Stage 2: source cell and fractional offset per axis
	// ---------------------------------------------------------------------
	logic               vld_s2;
	logic [63:0]        glyph_s2;
	agp_pkg::agp_cols_t cols_s2;
	agp_pkg::zoom_t     zc_s2;
	logic [2:0]         x0_s2, y0_s2;
	agp_pkg::zoom_t     rx_s2, ry_s2;

	logic [6:0]         xdiv_d, ydiv_d;

	always_comb begin
		xdiv_d = coord_div(px_s1, zc_s1);
		ydiv_d = coord_div(py_s1, zc_s1);
	end

	// ---------------------------------------------------------------------
	// Stage 3: fetch the four neighbor bits, horizontal weight per row
	// ---------------------------------------------------------------------
	logic               vld_s3;
	agp_pkg::agp_cols_t cols_s3;
	agp_pkg::zoom_t     zc_s3;
	agp_pkg::zoom_t     h0_s3, h1_s3, wy0_s3, wy1_s3;

	logic [2:0]         x1_d, y1_d;
	logic               b00, b01, b10, b11;
	agp_pkg::zoom_t     wx0_d, h0_d, h1_d;

	always_comb begin
		// neighbor past the last row or column clamps to 7
		x1_d  = (x0_s2 == 3'd7) ? 3'd7 : x0_s2 + 3'd1;
		y1_d  = (y0_s2 == 3'd7) ? 3'd7 : y0_s2 + 3'd1;
		b00   = glyph_s2[{y0_s2, x0_s2}];
		b01   = glyph_s2[{y0_s2, x1_d}];
		b10   = glyph_s2[{y1_d, x0_s2}];
		b11   = glyph_s2[{y1_d, x1_d}];
		wx0_d = zc_s2 - rx_s2;
		h0_d  = (b00 ? wx0_d : '0) + (b01 ? rx_s2 : '0);
		h1_d  = (b10 ? wx0_d : '0) + (b11 ? rx_s2 : '0);
	end

	// ---------------------------------------------------------------------
	// Stage 4: weight sum S and zoom squared
	// ---------------------------------------------------------------------
	logic               vld_s4;
	agp_pkg::agp_cols_t cols_s4;
	agp_pkg::wsum_t     wsum_s4, zz_s4;

	agp_pkg::wsum_t     wsum_d, zz_d;

	always_comb begin
		wsum_d = agp_pkg::wsum_t'(agp_pkg::wsum_t'(wy0_s3) * agp_pkg::wsum_t'(h0_s3)
		       + agp_pkg::wsum_t'(wy1_s3) * agp_pkg::wsum_t'(h1_s3));
		zz_d   = agp_pkg::wsum_t'(zc_s3) * agp_pkg::wsum_t'(zc_s3);
	end

	// ---------------------------------------------------------------------
	// Stages 5..7: rounded alpha
	// ---------------------------------------------------------------------
	logic               vld_s7;
	agp_pkg::alpha_t    alpha_s7;
	agp_pkg::agp_cols_t cols_s7;

	agp_alpha_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (vld_s4),
		.wsum     (wsum_s4),
		.zz       (zz_s4),
		.cols     (cols_s4),
		.res_vld  (vld_s7),
		.quot     (alpha_s7),
		.res_cols (cols_s7)
	);

	// ---------------------------------------------------------------------
	// Stage 8: per-channel weighted sums f*a + b*(255-a)
	// Alpha 255 and 0 land exactly on fore / back through the same math.
	// ---------------------------------------------------------------------
	logic               vld_s8;
	agp_pkg::alpha_t    alpha_s8;
	logic [MW-1:0]      mr_s8, mg_s8, mb_s8;

	agp_pkg::alpha_t    na_d;
	logic [MW-1:0]      mr_d, mg_d, mb_d;

	always_comb begin
		na_d = 8'd255 - alpha_s7;
		mr_d = MW'(MW'(cols_s7.fore[15:11]) * MW'(alpha_s7)
		     + MW'(cols_s7.back[15:11]) * MW'(na_d));
		mg_d = MW'(MW'(cols_s7.fore[10:5]) * MW'(alpha_s7)
		     + MW'(cols_s7.back[10:5]) * MW'(na_d));
		mb_d = MW'(MW'(cols_s7.fore[4:0]) * MW'(alpha_s7)
		     + MW'(cols_s7.back[4:0]) * MW'(na_d));
	end

	// ---------------------------------------------------------------------
	// Stage 9: divide by 255, pack RGB565, swap bytes for the link
	// ---------------------------------------------------------------------
	logic               vld_s9;
	agp_pkg::agp_rsp_t  rsp_s9;

	logic [5:0]         cr_d, cg_d, cb_d;
	logic [15:0]        word_d;

	always_comb begin
		cr_d   = div255(mr_s8);
		cg_d   = div255(mg_s8);
		cb_d   = div255(mb_s8);
		word_d = {cr_d[4:0], cg_d, cb_d[4:0]};
	end

	// ---------------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		glyph_s1     <= req.glyph_bits;
		cols_s1.fore <= req.fore_color;
		cols_s1.back <= req.back_color;
		zc_s1        <= zc_d;
		px_s1        <= px_d;
		py_s1        <= py_d;

		glyph_s2     <= glyph_s1;
		cols_s2      <= cols_s1;
		zc_s2        <= zc_s1;
		x0_s2        <= xdiv_d[6:4];
		rx_s2        <= xdiv_d[3:0];
		y0_s2        <= ydiv_d[6:4];
		ry_s2        <= ydiv_d[3:0];

		cols_s3      <= cols_s2;
		zc_s3        <= zc_s2;
		h0_s3        <= h0_d;
		h1_s3        <= h1_d;
		wy0_s3       <= zc_s2 - ry_s2;
		wy1_s3       <= ry_s2;

		cols_s4      <= cols_s3;
		wsum_s4      <= wsum_d;
		zz_s4        <= zz_d;

		alpha_s8     <= alpha_s7;
		mr_s8        <= mr_d;
		mg_s8        <= mg_d;
		mb_s8        <= mb_d;

		rsp_s9.pixel_word     <= {word_d[7:0], word_d[15:8]};
		rsp_s9.coverage_alpha <= alpha_s8;
	end

	assign busy = 1'b0;
	assign done = vld_s9;
	assign rsp  = rsp_s9;

endmodule

>>> hw/rtl/agp_checker.sv
module agp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input agp_pkg::agp_req_t req,
	input logic              done,
	input agp_pkg::agp_rsp_t rsp
);

	localparam int LAT = agp_pkg::LATENCY;

	// every accepted beat produces its result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result missing after fixed latency");

	// no result without a beat accepted the fixed latency earlier
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching request");

	// full coverage passes the foreground through, byte swapped
	a_full_fore: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.coverage_alpha == 8'd255 |->
		rsp.pixel_word == {$past(req.fore_color[7:0], LAT), $past(req.fore_color[15:8], LAT)})
		else $error("alpha 255 does not give foreground");

	// zero coverage passes the background through, byte swapped
	a_zero_back: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.coverage_alpha == 8'd0 |->
		rsp.pixel_word == {$past(req.back_color[7:0], LAT), $past(req.back_color[15:8], LAT)})
		else $error("alpha 0 does not give background");

endmodule

bind antialiased_glyph_pixel_core agp_checker u_agp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);

>>> bench/antialiased_glyph_pixel_core_tb.sv
`timescale 1ns / 1ps

// Stimulus and scoreboard for the glyph pixel core.
// One sender task drives request beats. A monitor on the done strobe checks each
// result beat against a queue of predicted pixels.
module antialiased_glyph_pixel_core_tb;

	localparam int ZOOM_CAP    = agp_pkg::DEF_MAX_ZOOM;
	localparam int ZW          = agp_pkg::ZOOM_W;
	localparam int CRW         = agp_pkg::COORD_W;
	localparam int CYCLE_LIMIT = 200000;   // roughly 30x the slowest legal run
	localparam int TAIL_CYCLES = agp_pkg::LATENCY + 4;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	agp_pkg::agp_req_t req    = '0;
	logic              busy;
	logic              done;
	agp_pkg::agp_rsp_t rsp;

	agp_pkg::agp_rsp_t pending_pixels[$];    // predicted beats, oldest first
	int unsigned       mismatch_count = 0;
	int unsigned       pixels_sent    = 0;
	int unsigned       pixels_checked = 0;
	int unsigned       cycle_count    = 0;
	bit                gap_burst      = 1'b0; // when set, the sender never idles

	antialiased_glyph_pixel_core #(
		.MAX_ZOOM(ZOOM_CAP)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Pixel predictor
	// ---------------------------------------------------------------

	// Glyph bit at (row, col): row picks the byte, col the bit in it.
	function automatic int unsigned glyph_at(input logic [63:0] g, input int unsigned row,
			input int unsigned col);
		logic [5:0] idx;
		idx = {row[2:0], col[2:0]};
		return g[idx];
	endfunction

	// Truncating weighted mean of one color channel.
	function automatic int unsigned mix_chan(input int unsigned f, input int unsigned b,
			input int unsigned a);
		return (f * a + b * (255 - a)) / 255;
	endfunction

	function automatic agp_pkg::agp_rsp_t predict_pixel(input agp_pkg::agp_req_t p);
		int unsigned       z, lim, px, py, x0, y0, x1, y1, rx, ry, wsum, zz, a, word;
		agp_pkg::agp_rsp_t r;
		// zoom 0 acts as 1; anything past the cap saturates
		z = p.zoom;
		if (z == 0) z = 1;
		if (z > ZOOM_CAP) z = ZOOM_CAP;
		// coordinates outside the scaled glyph pin to its last row/column
		lim = 8 * z - 1;
		px  = (p.pixel_x > lim) ? lim : p.pixel_x;
		py  = (p.pixel_y > lim) ? lim : p.pixel_y;
		x0  = px / z;
		rx  = px % z;
		y0  = py / z;
		ry  = py % z;
		// right/lower neighbor clamps to index 7
		x1  = (x0 + 1 < 8) ? x0 + 1 : 7;
		y1  = (y0 + 1 < 8) ? y0 + 1 : 7;
		wsum = glyph_at(p.glyph_bits, y0, x0) * (z - rx) * (z - ry)
		     + glyph_at(p.glyph_bits, y0, x1) * rx * (z - ry)
		     + glyph_at(p.glyph_bits, y1, x0) * (z - rx) * ry
		     + glyph_at(p.glyph_bits, y1, x1) * rx * ry;
		// round-half-up of 255 * wsum / zz
		zz = z * z;
		a  = (510 * wsum + zz) / (2 * zz);
		if (a > 255) a = 255;
		if (a == 255) begin
			word = p.fore_color;
		end else if (a == 0) begin
			word = p.back_color;
		end else begin
			word = (mix_chan(p.fore_color[15:11], p.back_color[15:11], a) << 11)
			     | (mix_chan(p.fore_color[10:5], p.back_color[10:5], a) << 5)
			     |  mix_chan(p.fore_color[4:0], p.back_color[4:0], a);
		end
		// bytes swapped for the link
		r.pixel_word     = {word[7:0], word[15:8]};
		r.coverage_alpha = a[7:0];
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Scoreboard
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("tb: mismatch on %s: got %h, want %h (t=%0t)", what, got, want, $time);
		mismatch_count++;
	endtask

	// Sampled at the edge that ends the done cycle. The core cannot be stalled,
	// so every strobe is one beat.
	always @(posedge clk) begin
		agp_pkg::agp_rsp_t want;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("result with no pending pixel", 32'(rsp), 0);
			end else begin
				want = pending_pixels.pop_front();
				pixels_checked++;
				if (rsp.pixel_word !== want.pixel_word)
					report_mismatch("pixel_word", 32'(rsp.pixel_word),
						32'(want.pixel_word));
				if (rsp.coverage_alpha !== want.coverage_alpha)
					report_mismatch("coverage_alpha", 32'(rsp.coverage_alpha),
						32'(want.coverage_alpha));
			end
		end
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d pixels pending", cycle_count,
				pending_pixels.size());
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------

	// Wait out a random idle gap first, unless in a burst stretch. A back-to-back beat
	// keeps start high, so it never gets two writes in one step.
	task automatic send_pixel(input agp_pkg::agp_req_t p);
		int unsigned gap;
		gap = gap_burst ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= p;
		do @(posedge clk); while (busy);
		pending_pixels.push_back(predict_pixel(p));
		pixels_sent++;
	endtask

	function automatic agp_pkg::agp_req_t mk_pixel(input logic [63:0] g,
			input logic [15:0] fg, input logic [15:0] bg, input int unsigned z,
			input int unsigned x, input int unsigned y);
		agp_pkg::agp_req_t p;
		p.glyph_bits = g;
		p.fore_color = fg;
		p.back_color = bg;
		p.zoom       = z[ZW-1:0];
		p.pixel_x    = x[CRW-1:0];
		p.pixel_y    = y[CRW-1:0];
		return p;
	endfunction

	function automatic logic [63:0] rand_glyph();
		logic [63:0] a, b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		// mix dense, sparse and plain glyphs so coverage hits 0, 255 and between
		case ($urandom_range(0, 3))
			0: return a & b;
			1: return a | b;
			default: return a;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Corners: pass-through alphas, zoom 0 and over-cap zoom, saturated
	// coordinates, clamped neighbors, exact half/quarter coverage, color extremes.
	task automatic test_directed();
		gap_burst = 1'b0;
		send_pixel(mk_pixel(64'h0, 16'hFFFF, 16'h0000, 1, 0, 0));           // alpha 0
		send_pixel(mk_pixel('1, 16'hFFFF, 16'h0000, 1, 7, 7));              // alpha 255
		send_pixel(mk_pixel('1, 16'h1234, 16'hABCD, 8, 63, 63));
		send_pixel(mk_pixel(64'h2, 16'hF800, 16'h001F, 0, 1, 0));           // zoom 0
		send_pixel(mk_pixel(64'h1, 16'h07E0, 16'hF81F, 15, 3, 3));          // over cap
		send_pixel(mk_pixel(64'h8000_0000_0000_0000, 16'hFFFF, 16'h0, 1, 63, 63));
		send_pixel(mk_pixel(64'h0000_0000_0000_0300, 16'hFFFF, 16'h0, 2, 40, 5));
		send_pixel(mk_pixel(64'h80, 16'hFFFF, 16'h0000, 8, 63, 0));         // column clamp
		send_pixel(mk_pixel(64'h0100_0000_0000_0000, 16'hFFFF, 16'h0, 4, 0, 31));
		gap_burst = 1'b1;
		send_pixel(mk_pixel(64'h1, 16'hFFFF, 16'h0000, 2, 1, 0));           // half
		send_pixel(mk_pixel(64'h1, 16'hFFFF, 16'h0000, 2, 1, 1));           // quarter
		send_pixel(mk_pixel(64'h1, 16'hFFFF, 16'h0000, 3, 1, 1));
		send_pixel(mk_pixel(64'hAA55_AA55_AA55_AA55, 16'hFFFF, 16'h0, 8, 4, 4));
		send_pixel(mk_pixel(64'h1, 16'h0000, 16'hFFFF, 2, 1, 0));
		send_pixel(mk_pixel(64'h1, 16'hF800, 16'h07E0, 5, 2, 3));
		send_pixel(mk_pixel(64'h3, 16'h001F, 16'hF81F, 6, 4, 2));
		gap_burst = 1'b0;
		send_pixel(mk_pixel(rand_glyph(), 16'($urandom), 16'($urandom), 7, 55, 55));
		send_pixel(mk_pixel(rand_glyph(), 16'($urandom), 16'($urandom), 7, 56, 60));
		send_pixel(mk_pixel(rand_glyph(), 16'($urandom), 16'($urandom), 5, 63, 0));
		send_pixel(mk_pixel(~64'h0000_0010_0000_0000, 16'hFFFF, 16'h8410, 3, 13, 13));
		send_pixel(mk_pixel(64'hFFFF_0000_FFFF_0000, 16'h5AA5, 16'hA55A, 8, 0, 63));
		send_pixel(mk_pixel(64'h0101_0101_0101_0101, 16'hFFFF, 16'h0, 8, 7, 20));
	endtask

	// Random pixels, mostly inside the scaled glyph with zoom in range; the rest
	// use any zoom code and any coordinate. Each run of 40 pixels is idle or burst at random.
	task automatic test_random_pixels(input int unsigned count);
		agp_pkg::agp_req_t p;
		int unsigned       z;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 40 == 0) gap_burst = $urandom_range(0, 2) == 0;
			p = mk_pixel(rand_glyph(), 16'($urandom), 16'($urandom), 0, 0, 0);
			if ($urandom_range(0, 99) < 85) begin
				z = $urandom_range(1, ZOOM_CAP);
				p.zoom    = z[ZW-1:0];
				p.pixel_x = CRW'($urandom_range(0, 8 * z - 1));
				p.pixel_y = CRW'($urandom_range(0, 8 * z - 1));
			end else begin
				p.zoom    = ZW'($urandom);
				p.pixel_x = CRW'($urandom);
				p.pixel_y = CRW'($urandom);
			end
			send_pixel(p);
		end
		gap_burst = 1'b0;
	endtask

	// Render one whole glyph at zoom 2, row by row, as a display would.
	task automatic test_glyph_scan();
		logic [63:0] g;
		logic [15:0] fg, bg;
		g  = rand_glyph();
		fg = 16'($urandom);
		bg = 16'($urandom);
		for (int unsigned y = 0; y < 16; y++) begin
			gap_burst = y[0];
			for (int unsigned x = 0; x < 16; x++)
				send_pixel(mk_pixel(g, fg, bg, 2, x, y));
		end
		gap_burst = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_glyph_scan();
		test_random_pixels(470);
		start <= 1'b0;

		// drain, then give the pipeline time to show any stray beat
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb: %0d pixels sent, %0d results checked, %0d mismatches", pixels_sent,
			pixels_checked, mismatch_count);
		$display("tb: covered zoom codes 0..15, saturated coordinates, edge clamps, idle gaps");
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
